FILE: hdl/ipwcd_pkg.sv
// shared constants and types for the ir pulse width character decoder
package ipwcd_pkg;

  // width of timestamps and of the wrapping interval arithmetic
  localparam int TIME_BITS = 32;

  // configuration register data width
  localparam int CFG_W = 16;

  // decoded character width
  localparam int CHAR_W = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEADER_MIN       = 2'd0,
    CFG_LEADER_SPACE_MIN = 2'd1,
    CFG_DATA_PULSE_MAX   = 2'd2,
    CFG_ONE_SPACE_MIN    = 2'd3
  } cfg_index_t;

  // threshold values after reset, in microseconds
  localparam logic [CFG_W-1:0] LEADER_MIN_RST       = 16'd8900;
  localparam logic [CFG_W-1:0] LEADER_SPACE_MIN_RST = 16'd3375;
  localparam logic [CFG_W-1:0] DATA_PULSE_MAX_RST   = 16'd648;
  localparam logic [CFG_W-1:0] ONE_SPACE_MIN_RST    = 16'd1120;

  // mask of the first received bit, which lands in the msb
  localparam logic [CHAR_W-1:0] FIRST_BIT_MASK = 8'h80;

endpackage

FILE: hdl/ir_pulse_width_char_decoder.sv
// ir pulse width character decoder: edge timing, leader check and bit assembly
//
// Usage: each request on the input channel (in_valid/in_ready) carries one
// sample of the active-low receiver pin (line_level) and its wrapping
// microsecond timestamp (now_us). A level change is an edge; the time since
// the previous edge is checked against the four thresholds. The user must write
// them through cfg_write/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this. After a valid leader pulse and space,
// eight data bits are collected msb first; the completed byte is offered on
// the output channel (out_valid/out_ready/char_value). Samples without a
// completed byte give no output.
// A sample is held in the input register, then its byte enters the output
// register. Throughput is one sample per cycle while no byte is stalled,
// set by the single decode stage that updates the phase and edge time on
// each edge. When the receiver stalls, samples that complete no byte keep
// flowing; a sample that completes a byte waits in the input register until
// the output register is free, and in_ready falls behind it.
// Reset (rst, synchronous) returns the phase to waiting for a leader, clears
// the line state, edge time and both registers' valid flags, and reloads the
// default thresholds.
module ir_pulse_width_char_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         line_level,
  input  logic [31:0]                  now_us,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ipwcd_pkg::CHAR_W-1:0] char_value,
  input  logic                         cfg_write,
  input  ipwcd_pkg::cfg_index_t        cfg_index,
  input  logic [ipwcd_pkg::CFG_W-1:0]  cfg_data
);
  import ipwcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_LEADER       = 3'd1,
    PH_LEADER_SPACE = 3'd2,
    PH_PULSE        = 3'd3,
    PH_SPACE        = 3'd4
  } phase_t;

  // configuration registers
  logic [CFG_W-1:0] leader_min_us;
  logic [CFG_W-1:0] leader_space_min_us;
  logic [CFG_W-1:0] data_pulse_max_us;
  logic [CFG_W-1:0] one_space_min_us;

  // input register
  logic                 s1_valid;
  logic                 s1_level;
  logic [TIME_BITS-1:0] s1_now;

  // decoder state
  phase_t               phase;
  logic                 line_active;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [CHAR_W-1:0]    char_bits;
  logic [CHAR_W-1:0]    bit_mask;

  // next-state values
  phase_t               phase_next;
  logic [CHAR_W-1:0]    char_bits_next;
  logic [CHAR_W-1:0]    bit_mask_next;
  logic                 produce;

  logic                 active;
  logic                 rising;
  logic                 falling;
  logic                 edge_seen;
  logic [TIME_BITS-1:0] ticks;
  logic                 s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_min_us       <= LEADER_MIN_RST;
      leader_space_min_us <= LEADER_SPACE_MIN_RST;
      data_pulse_max_us   <= DATA_PULSE_MAX_RST;
      one_space_min_us    <= ONE_SPACE_MIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEADER_MIN:       leader_min_us       <= cfg_data;
        CFG_LEADER_SPACE_MIN: leader_space_min_us <= cfg_data;
        CFG_DATA_PULSE_MAX:   data_pulse_max_us   <= cfg_data;
        CFG_ONE_SPACE_MIN:    one_space_min_us    <= cfg_data;
      endcase
    end
  end

  // edge detection and interval since the last edge
  assign active    = ~s1_level;
  assign rising    = active & ~line_active;
  assign falling   = ~active & line_active;
  assign edge_seen = rising | falling;
  assign ticks     = s1_now - last_edge_time;

  // phase machine
  always_comb begin
    phase_next     = phase;
    char_bits_next = char_bits;
    bit_mask_next  = bit_mask;
    produce        = 1'b0;
    unique case (phase)
      PH_LEADER: begin
        if (falling) begin
          phase_next = (ticks > TIME_BITS'(leader_min_us)) ? PH_LEADER_SPACE : PH_IDLE;
        end
      end
      PH_LEADER_SPACE: begin
        if (rising) begin
          if (ticks > TIME_BITS'(leader_space_min_us)) begin
            bit_mask_next  = FIRST_BIT_MASK;
            char_bits_next = '0;
            phase_next     = PH_PULSE;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_PULSE: begin
        if (falling) begin
          phase_next = (ticks < TIME_BITS'(data_pulse_max_us)) ? PH_SPACE : PH_IDLE;
        end
      end
      PH_SPACE: begin
        if (rising) begin
          if (ticks > TIME_BITS'(one_space_min_us)) begin
            char_bits_next = char_bits | bit_mask;
          end
          bit_mask_next = bit_mask >> 1;
          if (bit_mask_next == '0) begin
            produce    = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_PULSE;
          end
        end
      end
      default: begin
        phase_next = rising ? PH_LEADER : PH_IDLE;
      end
    endcase
    if (!edge_seen) begin
      produce = 1'b0;
    end
  end

  // handshake: a sample moves on unless it carries a byte into a full output that the receiver does not take
  assign s1_adv   = s1_valid & (~produce | ~out_valid | out_ready);
  assign in_ready = ~s1_valid | s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_level <= line_level;
      s1_now   <= TIME_BITS'(now_us);
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      line_active    <= 1'b0;
      last_edge_time <= '0;
      char_bits      <= '0;
      bit_mask       <= '0;
    end else if (s1_adv) begin
      line_active <= active;
      if (edge_seen) begin
        phase          <= phase_next;
        last_edge_time <= s1_now;
        char_bits      <= char_bits_next;
        bit_mask       <= bit_mask_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && produce) begin
      char_value <= char_bits_next;
    end
  end

  // the bit mask never holds more than one bit
  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bit_mask))
    else $error("bit mask holds several bits");

  // while collecting data bits a bit is always pending
  a_mask_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PULSE || phase == PH_SPACE) |-> bit_mask != '0)
    else $error("data phase with empty bit mask");

  // a new byte only follows a data space
  a_byte_source: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && produce) |-> phase == PH_SPACE && rising)
    else $error("byte completed outside a data space");

  // a held sample is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid && $stable(s1_now) && $stable(s1_level))
    else $error("stalled sample lost");

  // the byte register is not overwritten while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(s1_adv && produce))
    else $error("pending byte overwritten");

endmodule
